// ----- rtl/dfp_pkg.sv -----
// ----------------------------------------------------------------------------
// dfp_pkg
// Types, constants and helpers shared by the decimal fixed-point power block.
// ----------------------------------------------------------------------------
package dfp_pkg;

   localparam int BASE_DIGITS      = 6;
   localparam int BASE_W           = 24;
   localparam int FRAC_W           = 3;
   localparam int EXP_W            = 6;
   localparam int GROUP_DIGITS     = 16;
   localparam int MAX_GROUPS       = 16;
   localparam int GROUP_W          = GROUP_DIGITS * 4;
   localparam int GIDX_W           = 4;
   localparam int SIG_W            = 9;
   localparam int POINT_W          = 8;
   localparam int POINT_FULL_W     = FRAC_W + EXP_W;
   localparam int ACC_DIGITS       = BASE_DIGITS + 1;
   localparam int ACC_W            = ACC_DIGITS * 4;
   localparam int BSEL_W           = $clog2(BASE_DIGITS);
   localparam int MULT_ENTRIES     = 10;
   localparam int MAX_DIGITS_DEF   = 256;
   localparam int MAX_EXPONENT_DEF = 32;

   typedef struct packed {
      logic [BASE_W-1:0] base_bcd;
      logic [FRAC_W-1:0] base_fraction_digits;
      logic [EXP_W-1:0]  exponent;
   } req_type;

   typedef struct packed {
      logic [GROUP_W-1:0] digit_group;
      logic [GIDX_W-1:0]  group_index;
      logic [SIG_W-1:0]   significant_digits;
      logic [POINT_W-1:0] point_position;
      logic               last;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_STRIP,
      ST_TABLE,
      ST_LOAD,
      ST_PASS,
      ST_FILL,
      ST_SEND
   } state_type;

   function automatic logic group_is_bcd(input logic [GROUP_W-1:0] g);
      logic ok;
      ok = 1'b1;
      for (int i = 0; i < GROUP_DIGITS; i++) begin
         if (g[4*i +: 4] > 4'd9) ok = 1'b0;
      end
      return ok;
   endfunction

endpackage

// ----- rtl/dfp_bcd_adder.sv -----
// ----------------------------------------------------------------------------
// dfp_bcd_adder
// Ripple decimal adder over the accumulator width, shared by the table build
// and the digit-by-row multiply.
// ----------------------------------------------------------------------------
module dfp_bcd_adder (
   input  logic [dfp_pkg::ACC_W-1:0] a,
   input  logic [dfp_pkg::ACC_W-1:0] b,
   output logic [dfp_pkg::ACC_W-1:0] sum
);
   import dfp_pkg::*;

   always_comb begin
      logic       c;
      logic [4:0] s;
      c   = 1'b0;
      sum = '0;
      for (int i = 0; i < ACC_DIGITS; i++) begin
         s = {1'b0, a[4*i +: 4]} + {1'b0, b[4*i +: 4]} + {4'b0, c};
         if (s > 5'd9) begin
            s = s - 5'd10;
            c = 1'b1;
         end else begin
            c = 1'b0;
         end
         sum[4*i +: 4] = s[3:0];
      end
   end

endmodule

// ----- rtl/decimal_fixed_point_power.sv -----
// one transaction at a time, req_ready low until the last group leaves
// each pass streams the product digit memory through one bcd row adder
// reset clears the sequencer only; the digit memory is not cleared
// ----------------------------------------------------------------------------
// decimal_fixed_point_power
// Raises a short decimal fixed-point number to an integer power by repeated
// digit-by-row multiplication and returns the product as bcd groups.
// ----------------------------------------------------------------------------
module decimal_fixed_point_power #(
   parameter int MAX_DIGITS   = dfp_pkg::MAX_DIGITS_DEF,
   parameter int MAX_EXPONENT = dfp_pkg::MAX_EXPONENT_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  dfp_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output dfp_pkg::rsp_type rsp_data
);
   import dfp_pkg::*;

   localparam int AW = $clog2(MAX_DIGITS);
   localparam int IW = (AW + 1 > 9) ? AW + 1 : 9;
   localparam int LW = $clog2(MAX_DIGITS + 1);
   localparam int SW = ((LW > POINT_FULL_W) ? LW : POINT_FULL_W) + 1;

   function automatic logic [LW-1:0] base_len(input logic [BASE_W-1:0] b);
      logic [LW-1:0] n;
      n = '0;
      for (int i = 0; i < BASE_DIGITS; i++) begin
         if (b[4*i +: 4] != 4'd0) n = LW'(i + 1);
      end
      return n;
   endfunction

   function automatic logic [4:0] group_count(input logic [LW-1:0] len,
                                              input logic [POINT_FULL_W-1:0] pt);
      logic [SW-1:0] span;
      logic [SW-1:0] g;
      span = SW'(len);
      if (SW'(pt) > span) span = SW'(pt);
      if (span == '0) span = SW'(1);
      g = (span + SW'(GROUP_DIGITS - 1)) >> 4;
      if (g > SW'(MAX_GROUPS)) g = SW'(MAX_GROUPS);
      return 5'(g);
   endfunction

   state_type state_ff, state_in;

   logic [BASE_W-1:0]       base_ff, base_in;
   logic [FRAC_W-1:0]       frac_ff, frac_in;
   logic [EXP_W-1:0]        expo_ff, expo_in;
   logic [POINT_FULL_W-1:0] point_ff, point_in;
   logic [LW-1:0]           len_ff, len_in;
   logic [LW-1:0]           newlen_ff, newlen_in;
   logic [EXP_W-1:0]        pass_ff, pass_in;
   logic [IW-1:0]           idx_ff, idx_in;
   logic                    wb_valid_ff, wb_valid_in;
   logic [IW-1:0]           wb_idx_ff, wb_idx_in;
   logic [ACC_W-1:0]        carry_ff, carry_in;
   logic [ACC_W-1:0]        acc_ff, acc_in;
   logic [ACC_W-1:0]        mult_ff [MULT_ENTRIES];
   logic [ACC_W-1:0]        mult_in [MULT_ENTRIES];
   logic [3:0]              tk_ff, tk_in;
   logic [GIDX_W-1:0]       grp_ff, grp_in;
   logic [4:0]              groups_ff, groups_in;
   logic [4:0]              iss_ff, iss_in;
   logic [3:0]              cap_ff, cap_in;
   logic [GROUP_W-1:0]      group_ff, group_in;
   logic [3:0]              rd_data_ff;

   logic [3:0]              mem [MAX_DIGITS];
   logic                    mem_we;
   logic [AW-1:0]           mem_wa;
   logic [3:0]              mem_wd;

   logic [ACC_W-1:0]        add_a, add_b, add_sum;
   logic [3:0]              digit_m, mult_sel;
   logic [IW:0]             limit;
   logic                    issue;
   logic [BASE_W-1:0]       sat_base;
   logic                    last_grp;
   logic [LW+SIG_W-1:0]     len_x;

   dfp_bcd_adder u_adder (
      .a   (add_a),
      .b   (add_b),
      .sum (add_sum)
   );

   always_comb begin
      for (int i = 0; i < BASE_DIGITS; i++) begin
         sat_base[4*i +: 4] = (req_data.base_bcd[4*i +: 4] > 4'd9) ? 4'd9
                                                                  : req_data.base_bcd[4*i +: 4];
      end
   end

   assign digit_m  = ((IW+1)'(wb_idx_ff) < (IW+1)'(len_ff)) ? rd_data_ff : 4'd0;
   assign mult_sel = (digit_m > 4'd9) ? 4'd9 : digit_m;
   assign add_a    = (state_ff == ST_TABLE) ? acc_ff : mult_ff[mult_sel];
   assign add_b    = (state_ff == ST_TABLE) ? {4'd0, base_ff} : carry_ff;
   assign last_grp = ({1'b0, grp_ff} == groups_ff - 5'd1);

   always_comb begin
      limit = (IW+1)'(len_ff) + (IW+1)'(BASE_DIGITS);
      if (limit > (IW+1)'(MAX_DIGITS)) limit = (IW+1)'(MAX_DIGITS);
   end

   always_comb begin
      state_in    = state_ff;
      base_in     = base_ff;
      frac_in     = frac_ff;
      expo_in     = expo_ff;
      point_in    = point_ff;
      len_in      = len_ff;
      newlen_in   = newlen_ff;
      pass_in     = pass_ff;
      idx_in      = idx_ff;
      wb_valid_in = 1'b0;
      wb_idx_in   = idx_ff;
      carry_in    = carry_ff;
      acc_in      = acc_ff;
      mult_in     = mult_ff;
      tk_in       = tk_ff;
      grp_in      = grp_ff;
      groups_in   = groups_ff;
      iss_in      = iss_ff;
      cap_in      = cap_ff;
      group_in    = group_ff;
      mem_we      = 1'b0;
      mem_wa      = wb_idx_ff[AW-1:0];
      mem_wd      = add_sum[3:0];
      issue       = 1'b0;
      req_ready   = 1'b0;
      rsp_valid   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               base_in  = sat_base;
               frac_in  = (int'(req_data.base_fraction_digits) > BASE_DIGITS)
                          ? FRAC_W'(BASE_DIGITS) : req_data.base_fraction_digits;
               expo_in  = (int'(req_data.exponent) > MAX_EXPONENT)
                          ? EXP_W'(MAX_EXPONENT) : req_data.exponent;
               state_in = ST_STRIP;
            end
         end
         ST_STRIP: begin
            if (frac_ff != '0 && base_ff[3:0] == 4'd0) begin
               base_in = base_ff >> 4;
               frac_in = frac_ff - FRAC_W'(1);
            end else begin
               point_in   = (expo_ff == '0) ? '0
                            : {{EXP_W{1'b0}}, frac_ff} * {{FRAC_W{1'b0}}, expo_ff};
               len_in     = (expo_ff == '0) ? LW'(1) : base_len(base_ff);
               acc_in     = '0;
               mult_in[0] = '0;
               tk_in      = 4'd1;
               state_in   = ST_TABLE;
            end
         end
         ST_TABLE: begin
            mult_in[tk_ff] = add_sum;
            acc_in         = add_sum;
            tk_in          = tk_ff + 4'd1;
            if (tk_ff == 4'(MULT_ENTRIES - 1)) begin
               idx_in   = '0;
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            mem_we = 1'b1;
            mem_wa = idx_ff[AW-1:0];
            if (expo_ff == '0) mem_wd = (idx_ff == '0) ? 4'd1 : 4'd0;
            else mem_wd = base_ff[4*idx_ff[BSEL_W-1:0] +: 4];
            idx_in = idx_ff + IW'(1);
            if (idx_ff == IW'(BASE_DIGITS - 1)) begin
               idx_in    = '0;
               pass_in   = EXP_W'(2);
               carry_in  = '0;
               newlen_in = '0;
               if (expo_ff < EXP_W'(2)) begin
                  grp_in    = '0;
                  iss_in    = '0;
                  cap_in    = '0;
                  groups_in = group_count(len_ff, point_ff);
                  state_in  = ST_FILL;
               end else begin
                  state_in = ST_PASS;
               end
            end
         end
         ST_PASS: begin
            issue       = ({1'b0, idx_ff} < limit);
            wb_valid_in = issue;
            if (issue) idx_in = idx_ff + IW'(1);
            if (wb_valid_ff) begin
               mem_we   = 1'b1;
               carry_in = add_sum >> 4;
               if (add_sum[3:0] != 4'd0) newlen_in = LW'(wb_idx_ff + IW'(1));
            end
            if (!issue && !wb_valid_ff) begin
               len_in = newlen_ff;
               idx_in = '0;
               if (pass_ff == expo_ff) begin
                  grp_in    = '0;
                  iss_in    = '0;
                  cap_in    = '0;
                  groups_in = group_count(newlen_ff, point_ff);
                  state_in  = ST_FILL;
               end else begin
                  pass_in   = pass_ff + EXP_W'(1);
                  carry_in  = '0;
                  newlen_in = '0;
               end
            end
         end
         ST_FILL: begin
            issue       = !iss_ff[4];
            wb_valid_in = issue;
            if (issue) begin
               idx_in = idx_ff + IW'(1);
               iss_in = iss_ff + 5'd1;
            end
            if (wb_valid_ff) begin
               group_in = {digit_m, group_ff[GROUP_W-1:4]};
               cap_in   = cap_ff + 4'd1;
               if (cap_ff == 4'd15) state_in = ST_SEND;
            end
         end
         ST_SEND: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               if (last_grp) begin
                  state_in = ST_IDLE;
               end else begin
                  grp_in   = grp_ff + GIDX_W'(1);
                  iss_in   = '0;
                  cap_in   = '0;
                  state_in = ST_FILL;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         wb_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         wb_valid_ff <= wb_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      base_ff   <= base_in;
      frac_ff   <= frac_in;
      expo_ff   <= expo_in;
      point_ff  <= point_in;
      len_ff    <= len_in;
      newlen_ff <= newlen_in;
      pass_ff   <= pass_in;
      idx_ff    <= idx_in;
      wb_idx_ff <= wb_idx_in;
      carry_ff  <= carry_in;
      acc_ff    <= acc_in;
      mult_ff   <= mult_in;
      tk_ff     <= tk_in;
      grp_ff    <= grp_in;
      groups_ff <= groups_in;
      iss_ff    <= iss_in;
      cap_ff    <= cap_in;
      group_ff  <= group_in;
   end

   // product digit memory
   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_wa] <= mem_wd;
      rd_data_ff <= mem[idx_ff[AW-1:0]];
   end

   assign len_x = {{SIG_W{1'b0}}, len_ff};

   always_comb begin
      rsp_data                    = '0;
      rsp_data.digit_group        = group_ff;
      rsp_data.group_index        = grp_ff;
      rsp_data.significant_digits = len_x[SIG_W-1:0];
      rsp_data.point_position     = point_ff[POINT_W-1:0];
      rsp_data.last               = last_grp;
   end

`ifndef NO_ASSERTIONS
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while a transaction is in flight");

   a_group_is_bcd: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> group_is_bcd(rsp_data.digit_group))
      else $error("result group holds a non-decimal digit");

   a_idle_after_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_data.last |=> req_ready && !rsp_valid)
      else $error("block not idle after final group");

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("input open while a result is pending");
`endif

endmodule

// ----- tb/sv/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Drives decimal base/fraction/exponent transactions into the power block and
// checks every returned bcd digit group against an in-bench digit multiplier.
// ----------------------------------------------------------------------------
module testbench;
   import dfp_pkg::*;

   localparam int NDIG = 256;
   localparam int STALL_LIMIT = 200000;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   req_type pending_reqs[$];
   rsp_type expected_groups[$];
   int      error_count;
   int      idle_cycles;
   bit      calm;
   bit      hold_sink;
   bit      hold_source;
   bit      req_taken;
   int      src_gap;
   int      sink_gap;

   decimal_fixed_point_power dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
      $display("mismatch %s: got %0h want %0h", what, got, want);
      error_count++;
   endtask

   // schoolbook decimal power, appends the expected groups
   task automatic predict_power(input req_type r);
      logic [3:0] bdig[BASE_DIGITS];
      logic [3:0] prod[NDIG];
      int         col[NDIG];
      int         frac, expo, plen, point, span, groups, carry, v;
      logic [63:0] g;
      rsp_type    e;
      for (int i = 0; i < BASE_DIGITS; i++) begin
         bdig[i] = (r.base_bcd[4*i +: 4] > 4'd9) ? 4'd9 : r.base_bcd[4*i +: 4];
      end
      frac = r.base_fraction_digits;
      if (frac > BASE_DIGITS) frac = BASE_DIGITS;
      while (frac > 0 && bdig[0] == 4'd0) begin
         for (int i = 0; i + 1 < BASE_DIGITS; i++) bdig[i] = bdig[i+1];
         bdig[BASE_DIGITS-1] = 4'd0;
         frac--;
      end
      expo = r.exponent;
      if (expo > 32) expo = 32;
      for (int i = 0; i < NDIG; i++) prod[i] = 4'd0;
      if (expo == 0) begin
         prod[0] = 4'd1;
         point = 0;
      end else begin
         for (int i = 0; i < BASE_DIGITS; i++) prod[i] = bdig[i];
         point = frac * expo;
      end
      plen = NDIG;
      while (plen > 0 && prod[plen-1] == 4'd0) plen--;
      for (int k = 2; k <= expo; k++) begin
         for (int i = 0; i < NDIG; i++) col[i] = 0;
         for (int i = 0; i < plen; i++)
            for (int j = 0; j < BASE_DIGITS; j++)
               if (i + j < NDIG) col[i+j] += prod[i] * bdig[j];
         carry = 0;
         for (int i = 0; i < NDIG; i++) begin
            v = col[i] + carry;
            prod[i] = 4'(v % 10);
            carry = v / 10;
         end
         plen = NDIG;
         while (plen > 0 && prod[plen-1] == 4'd0) plen--;
      end
      span = plen;
      if (point > span) span = point;
      if (span < 1) span = 1;
      groups = (span + 15) / 16;
      if (groups > MAX_GROUPS) groups = MAX_GROUPS;
      for (int k = 0; k < groups; k++) begin
         g = '0;
         for (int i = 0; i < 16; i++) g[4*i +: 4] = prod[k*16 + i];
         e.digit_group        = g;
         e.group_index        = k[3:0];
         e.significant_digits = plen[8:0];
         e.point_position     = point[7:0];
         e.last               = (k + 1 == groups);
         expected_groups.push_back(e);
      end
   endtask

   function automatic req_type make_req(input logic [23:0] b, input int f, input int x);
      req_type r;
      r.base_bcd = b;
      r.base_fraction_digits = f[2:0];
      r.exponent = x[5:0];
      return r;
   endfunction

   function automatic logic [23:0] rand_decimal(input int ndig);
      logic [23:0] b;
      b = '0;
      for (int i = 0; i < ndig; i++) b[4*i +: 4] = 4'($urandom_range(0, 9));
      return b;
   endfunction

   // accept seen at the last rising edge
   always @(posedge clock) begin
      req_taken <= req_valid && req_ready;
   end

   // driver
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_taken) begin
      end else if (src_gap > 0) begin
         req_valid <= 1'b0;
         src_gap <= src_gap - 1;
      end else if (hold_source || pending_reqs.size() == 0) begin
         req_valid <= 1'b0;
      end else begin
         req_data  <= pending_reqs.pop_front();
         req_valid <= 1'b1;
         if (!calm && $urandom_range(0, 5) == 0) src_gap <= $urandom_range(1, 7);
      end
   end

   // receiver idling
   always @(negedge clock) begin
      if (reset || hold_sink) begin
         rsp_ready <= 1'b0;
      end else if (sink_gap > 0) begin
         rsp_ready <= 1'b0;
         sink_gap <= sink_gap - 1;
      end else begin
         rsp_ready <= 1'b1;
         if (!calm && $urandom_range(0, 4) == 0) sink_gap <= $urandom_range(1, 7);
      end
   end

   // monitor
   always @(posedge clock) begin
      rsp_type e;
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (req_valid && req_ready) predict_power(req_data);
         if (rsp_valid && rsp_ready) begin
            if (expected_groups.size() == 0) begin
               report("unexpected transaction", rsp_data.digit_group, 0);
            end else begin
               e = expected_groups.pop_front();
               if (rsp_data.digit_group !== e.digit_group)
                  report("digit_group", rsp_data.digit_group, e.digit_group);
               if (rsp_data.group_index !== e.group_index)
                  report("group_index", rsp_data.group_index, e.group_index);
               if (rsp_data.significant_digits !== e.significant_digits)
                  report("significant_digits", rsp_data.significant_digits,
                         e.significant_digits);
               if (rsp_data.point_position !== e.point_position)
                  report("point_position", rsp_data.point_position, e.point_position);
               if (rsp_data.last !== e.last)
                  report("last", rsp_data.last, e.last);
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (idle_cycles >= STALL_LIMIT) begin
         $display("testbench: done, errors");
         $finish;
      end
   end

   initial begin
      int x;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_ready = 1'b0;
      error_count = 0;
      idle_cycles = 0;
      calm = 1'b0;
      hold_sink = 1'b0;
      hold_source = 1'b0;
      src_gap = 0;
      sink_gap = 0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed corners
      pending_reqs.push_back(make_req(24'h000000, 0, 1));
      pending_reqs.push_back(make_req(24'h000000, 5, 7));
      pending_reqs.push_back(make_req(24'h000000, 7, 0));
      pending_reqs.push_back(make_req(24'h123456, 3, 0));
      pending_reqs.push_back(make_req(24'h999999, 0, 32));
      pending_reqs.push_back(make_req(24'h999999, 5, 32));
      pending_reqs.push_back(make_req(24'hffffff, 7, 63));
      pending_reqs.push_back(make_req(24'hfafafa, 6, 40));
      pending_reqs.push_back(make_req(24'h000001, 0, 1));
      pending_reqs.push_back(make_req(24'h100000, 5, 3));
      pending_reqs.push_back(make_req(24'h120000, 4, 5));
      pending_reqs.push_back(make_req(24'h000010, 1, 2));
      pending_reqs.push_back(make_req(24'h000002, 0, 33));
      pending_reqs.push_back(make_req(24'h000005, 5, 32));
      pending_reqs.push_back(make_req(24'h000001, 5, 32));
      pending_reqs.push_back(make_req(24'h555555, 2, 31));
      pending_reqs.push_back(make_req(24'h00000c, 0, 2));
      pending_reqs.push_back(make_req(24'h123456, 7, 1));
      wait (pending_reqs.size() == 0);

      // receiver holds off while the sender keeps offering
      hold_sink = 1'b1;
      for (int i = 0; i < 6; i++)
         pending_reqs.push_back(make_req(rand_decimal(6), $urandom_range(0, 5), 3));
      repeat (3000) @(posedge clock);
      hold_sink = 1'b0;

      // sender pauses until the result queue is empty
      wait (pending_reqs.size() == 0);
      hold_source = 1'b1;
      @(negedge clock);
      wait (!req_valid);
      wait (expected_groups.size() == 0);
      hold_source = 1'b0;

      for (int n = 0; n < 130; n++) begin
         if (n == 110) begin
            wait (pending_reqs.size() == 0);
            calm = 1'b1;
         end
         x = $urandom_range(0, 9);
         if (x == 0)
            pending_reqs.push_back(make_req($urandom, $urandom_range(0, 7),
                                            $urandom_range(0, 63)));
         else if (x == 1)
            pending_reqs.push_back(make_req(rand_decimal(6), $urandom_range(0, 5),
                                            $urandom_range(20, 32)));
         else
            pending_reqs.push_back(make_req(rand_decimal($urandom_range(1, 6)),
                                            $urandom_range(0, 5),
                                            $urandom_range(1, 8)));
         if (pending_reqs.size() > 4) wait (pending_reqs.size() <= 2);
      end
      wait (pending_reqs.size() == 0);
      @(negedge clock);
      wait (!req_valid);
      wait (expected_groups.size() == 0);
      repeat (200) @(posedge clock);
      if (error_count == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end

endmodule
